>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MPQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpq assertion failed");

// next-cycle implication, disabled while in reset
`define MPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpq assertion failed");

`endif

>>> rtl/core/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types, codes and defaults shared by the priority queue modules.
// ----------------------------------------------------------------------------
package mpq_pkg;

   localparam int KEY_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 7;
   localparam int CAPACITY_D = 64;

   // request operation codes
   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // key returned on an insert or an empty extract
   localparam logic signed [KEY_W-1:0] EMPTY_KEY = '1;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic                    insert;
      logic                    extract;
      logic signed [KEY_W-1:0] new_key;
   } mpq_ctrl_type;

endpackage

>>> rtl/core/mpq_if.sv
// ----------------------------------------------------------------------------
// mpq request and response channels
// Valid/ready channels carrying the request and the result item.
// ----------------------------------------------------------------------------
interface mpq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic signed [mpq_pkg::KEY_W-1:0]    key;

   modport source (output valid, output func, output key, input ready);
   modport sink   (input valid, input func, input key, output ready);
endinterface

interface mpq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mpq_pkg::KEY_W-1:0]    min_key;
   logic        [mpq_pkg::STATUS_W-1:0] status;
   logic        [mpq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output min_key, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input min_key, input status, input occupancy,
                   output ready);
endinterface

>>> rtl/core/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted key row: holds a key, shifts right on insert
// (making room for the new key) and left on extract.
// ----------------------------------------------------------------------------
module mpq_cell (
   input  logic                             clock,
   input  mpq_pkg::mpq_ctrl_type            ctrl,
   input  logic                             cell_valid,
   input  logic                             left_less,
   input  logic signed [mpq_pkg::KEY_W-1:0] left_key,
   input  logic signed [mpq_pkg::KEY_W-1:0] right_key,
   output logic                             less,
   output logic signed [mpq_pkg::KEY_W-1:0] key
);

   logic signed [mpq_pkg::KEY_W-1:0] key_ff;
   logic signed [mpq_pkg::KEY_W-1:0] key_in;

   // new key sorts before this slot (empty slots count as +infinity)
   assign less = !cell_valid || (ctrl.new_key < key_ff);

   // next slot contents
   always_comb begin
      key_in = key_ff;
      if (ctrl.insert && less) begin
         key_in = left_less ? left_key : ctrl.new_key;
      end else if (ctrl.extract) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

>>> rtl/core/min_priority_queue.sv
// ----------------------------------------------------------------------------
// min_priority_queue
// Priority queue of signed keys built as a sorted row of cells: insert
// or extract the minimum, one result item per request.
// ----------------------------------------------------------------------------
//  channel | dir | fields                       | accepted when
//  req_if  | in  | func, key                    | valid && ready
//  rsp_if  | out | min_key, status, occupancy   | valid && ready
//
//  for each request item every cell compares its key with the new key in
//  parallel and the row shifts one place, so an item can enter every
//  cycle while the result register is free or being emptied.
//  the result register holds one item; req_if.ready drops while it is full
//  and rsp_if.ready is low.
//  synchronous reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_priority_queue #(
   parameter int CAPACITY = mpq_pkg::CAPACITY_D
) (
   input  logic        clock,
   input  logic        reset,
   mpq_req_if.sink     req_if,
   mpq_rsp_if.source   rsp_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]                        count_ff;
   logic [CNT_W-1:0]                        count_in;
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic signed [mpq_pkg::KEY_W-1:0]        rsp_key_ff;
   logic signed [mpq_pkg::KEY_W-1:0]        rsp_key_in;
   logic        [mpq_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic        [mpq_pkg::STATUS_W-1:0]     rsp_status_in;

   logic                                    accept;
   logic                                    full;
   logic                                    empty;
   mpq_pkg::mpq_ctrl_type                   ctrl;

   logic signed [mpq_pkg::KEY_W-1:0]        cell_key  [CAPACITY];
   logic                                    cell_less [CAPACITY];

   // handshake
   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign empty        = (count_ff == '0);

   // broadcast control to the row
   always_comb begin
      ctrl.insert  = accept && (req_if.func == mpq_pkg::FUNC_INSERT) && !full;
      ctrl.extract = accept && (req_if.func == mpq_pkg::FUNC_EXTRACT) && !empty;
      ctrl.new_key = req_if.key;
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                             left_less;
      logic signed [mpq_pkg::KEY_W-1:0] left_key;
      logic signed [mpq_pkg::KEY_W-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_less = 1'b0;
         assign left_key  = req_if.key;
      end else begin : g_mid
         assign left_less = cell_less[i-1];
         assign left_key  = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      mpq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_valid (CNT_W'(i) < count_ff),
         .left_less  (left_less),
         .left_key   (left_key),
         .right_key  (right_key),
         .less       (cell_less[i]),
         .key        (cell_key[i])
      );
   end

   // key count and result register next values
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = mpq_pkg::EMPTY_KEY;
         rsp_status_in = mpq_pkg::ST_OK;
         if (req_if.func == mpq_pkg::FUNC_INSERT) begin
            if (full) begin
               rsp_status_in = mpq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               rsp_status_in = mpq_pkg::ST_EMPTY;
            end else begin
               rsp_key_in = cell_key[0];
               count_in   = count_ff - 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.min_key   = rsp_key_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.occupancy = mpq_pkg::OCC_W'(count_ff);

   // checks
   `MPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `MPQ_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.insert,
                    count_ff == $past(count_ff) + 1'b1)
   `MPQ_ASSERT_NEXT(a_extract_shrinks, clock, reset, ctrl.extract,
                    count_ff == $past(count_ff) - 1'b1)
   `MPQ_ASSERT_NOW(a_empty_status, clock, reset,
                   rsp_valid_ff && (rsp_status_ff == mpq_pkg::ST_EMPTY),
                   (count_ff == '0) && (rsp_key_ff == mpq_pkg::EMPTY_KEY))
   `MPQ_ASSERT_NOW(a_head_sorted, clock, reset, count_ff > CNT_W'(1),
                   cell_key[0] <= cell_key[1])

endmodule

>>> bench/min_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// min_priority_queue_tb
// Self-checking bench for the priority queue: sends insert and extract items,
// keeps a sorted copy of the held keys to predict each result item, and
// compares every result field by field under changing back-pressure.
// ----------------------------------------------------------------------------
module min_priority_queue_tb;

   localparam int CLK_HALF     = 4;
   localparam int CAPACITY     = mpq_pkg::CAPACITY_D;
   localparam int RUN_LIMIT    = 2_000_000;
   localparam int RANDOM_ITEMS = 140;
   localparam int MAX_REPORTS  = 50;

   localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [mpq_pkg::KEY_W-1:0] min_key;
      logic [mpq_pkg::STATUS_W-1:0]     status;
      logic [mpq_pkg::OCC_W-1:0]        occupancy;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;

   mpq_req_if req_ch ();
   mpq_rsp_if rsp_ch ();

   min_priority_queue #(
      .CAPACITY (CAPACITY)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predicted contents of the queue, ascending
   logic signed [mpq_pkg::KEY_W-1:0] sorted_keys[$];
   queue_result_type                 pending_results[$];

   int fail_count     = 0;
   int checked_count  = 0;
   int insert_count   = 0;
   int extract_count  = 0;
   int empty_count    = 0;
   int dropped_count  = 0;
   int peak_occupancy = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // clock
   always #(CLK_HALF) clock = ~clock;

   // run limit
   initial begin
      #(RUN_LIMIT);
      $display("timeout with %0d result items outstanding", pending_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // apply one request to the predicted queue and return its result
   function automatic queue_result_type predict_request(
      input logic                             op,
      input logic signed [mpq_pkg::KEY_W-1:0] k);
      queue_result_type res;
      int               pos;
      res.min_key = mpq_pkg::EMPTY_KEY;
      res.status  = mpq_pkg::ST_OK;
      if (op == mpq_pkg::FUNC_INSERT) begin
         insert_count++;
         if (sorted_keys.size() >= CAPACITY) begin
            res.status = mpq_pkg::ST_FULL;
            dropped_count++;
         end else begin
            // new key goes after every key not greater than it
            pos = sorted_keys.size();
            while (pos > 0 && k < sorted_keys[pos-1]) pos--;
            sorted_keys.insert(pos, k);
         end
      end else begin
         extract_count++;
         if (sorted_keys.size() == 0) begin
            res.status = mpq_pkg::ST_EMPTY;
            empty_count++;
         end else begin
            res.min_key = sorted_keys.pop_front();
         end
      end
      res.occupancy = mpq_pkg::OCC_W'(sorted_keys.size());
      if (sorted_keys.size() > peak_occupancy) peak_occupancy = sorted_keys.size();
      return res;
   endfunction

   task automatic report_mismatch(input string field,
                                  input logic signed [mpq_pkg::KEY_W-1:0] want,
                                  input logic signed [mpq_pkg::KEY_W-1:0] got);
      if (fail_count < MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
   endtask

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin : result_check
      queue_result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            pending_results.insert(pending_results.size(),
                                   predict_request(req_ch.func, req_ch.key));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: unexpected result item, expected none, got %0d/%0d/%0d",
                           $time, rsp_ch.min_key, rsp_ch.status, rsp_ch.occupancy);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               checked_count++;
               if (rsp_ch.min_key !== want.min_key)
                  report_mismatch("min_key", want.min_key, rsp_ch.min_key);
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", want.status, rsp_ch.status);
               if (rsp_ch.occupancy !== want.occupancy)
                  report_mismatch("occupancy", want.occupancy, rsp_ch.occupancy);
            end
         end
      end
   end

   // key mix: small values for duplicates, extremes, and full-range values
   function automatic logic signed [mpq_pkg::KEY_W-1:0] pick_key();
      logic signed [mpq_pkg::KEY_W-1:0] k;
      case ($urandom_range(0, 5))
         0: begin
            k = $urandom_range(0, 8);
            k = k - 4;
         end
         1: begin
            case ($urandom_range(0, 3))
               0:       k = KEY_MIN;
               1:       k = KEY_MAX;
               2:       k = '0;
               default: k = mpq_pkg::EMPTY_KEY;
            endcase
         end
         default: k = $urandom();
      endcase
      return k;
   endfunction

   // send one item; starts and ends on a falling edge
   task automatic send_item(input logic op, input logic signed [mpq_pkg::KEY_W-1:0] k);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= op;
      req_ch.key   <= k;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
   endtask

   // extremes, duplicates, extracting -1 itself, empty extracts
   task automatic test_directed();
      send_item(mpq_pkg::FUNC_EXTRACT, pick_key());
      send_item(mpq_pkg::FUNC_INSERT, '0);
      send_item(mpq_pkg::FUNC_INSERT, mpq_pkg::EMPTY_KEY);
      send_item(mpq_pkg::FUNC_INSERT, KEY_MAX);
      send_item(mpq_pkg::FUNC_INSERT, KEY_MIN);
      send_item(mpq_pkg::FUNC_INSERT, 32'sd5);
      send_item(mpq_pkg::FUNC_INSERT, 32'sd5);
      send_item(mpq_pkg::FUNC_INSERT, mpq_pkg::EMPTY_KEY);
      repeat (7) send_item(mpq_pkg::FUNC_EXTRACT, pick_key());
      send_item(mpq_pkg::FUNC_EXTRACT, pick_key());
      send_item(mpq_pkg::FUNC_INSERT, 32'sh5555_5555);
      send_item(mpq_pkg::FUNC_INSERT, 32'shaaaa_aaaa);
      send_item(mpq_pkg::FUNC_INSERT, 32'sd1);
      repeat (3) send_item(mpq_pkg::FUNC_EXTRACT, KEY_MAX);
      send_item(mpq_pkg::FUNC_EXTRACT, KEY_MIN);
   endtask

   // random traffic in bursts that lean towards growing or shrinking
   task automatic test_random_mix(input int n_items);
      int insert_pct = 50;
      int burst_left = 0;
      for (int i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 20;
            endcase
         end
         burst_left--;
         if ($urandom_range(0, 99) < insert_pct)
            send_item(mpq_pkg::FUNC_INSERT, pick_key());
         else
            send_item(mpq_pkg::FUNC_EXTRACT, pick_key());
      end
   endtask

   // drain, fill to capacity, overflow, reuse the freed slot, drain past empty
   task automatic test_full_queue();
      while (sorted_keys.size() != 0) send_item(mpq_pkg::FUNC_EXTRACT, pick_key());
      while (sorted_keys.size() < CAPACITY) send_item(mpq_pkg::FUNC_INSERT, pick_key());
      repeat (3) send_item(mpq_pkg::FUNC_INSERT, pick_key());
      send_item(mpq_pkg::FUNC_EXTRACT, pick_key());
      send_item(mpq_pkg::FUNC_INSERT, KEY_MIN);
      send_item(mpq_pkg::FUNC_INSERT, KEY_MAX);
      repeat (CAPACITY + 1) send_item(mpq_pkg::FUNC_EXTRACT, pick_key());
   endtask

   // test sequence
   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func  = mpq_pkg::FUNC_INSERT;
      req_ch.key   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_directed();
      test_random_mix(RANDOM_ITEMS);

      set_idling(67, 0);
      test_random_mix(RANDOM_ITEMS);

      set_idling(0, 67);
      test_random_mix(RANDOM_ITEMS);
      test_full_queue();

      set_idling(34, 34);
      test_full_queue();
      test_random_mix(RANDOM_ITEMS);

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("run covered %0d inserts (%0d dropped when full) and %0d extracts (%0d empty)",
               insert_count, dropped_count, extract_count, empty_count);
      $display("%0d result items checked, peak occupancy %0d, %0d failures",
               checked_count, peak_occupancy, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
